>>> rtl/bm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_pkg: shared types and constants for the 3x3 binary morphology block
// Register indexes, pixel flag layout, hit patterns and per-pixel tags.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // widest configuration register
  localparam int CFG_W = 10;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // mode values
  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  localparam logic [7:0] FULL_VAL = 8'd255;

  // per-pixel flag pair: bit 0 nonzero, bit 1 full
  localparam int FLAG_NZ   = 0;
  localparam int FLAG_FULL = 1;
  localparam int FLAG_W    = 2;

  // line store entry: {middle row, top row}
  localparam int LB_W = 2 * FLAG_W;

  // window column: {south, centre, north} flags
  localparam int COL_W = 3 * FLAG_W;
  localparam int WIN_W = 3 * COL_W;

  // erosion hit patterns over the neighbour mask {se,s,sw,w,nw,n,ne,e}
  localparam logic [7:0] HIT_ISOLATED = 8'h00;
  localparam logic [7:0] HIT_E_NE_N   = 8'h07;
  localparam logic [7:0] HIT_SE_ONLY  = 8'h80;

  // position tags carried down the pipeline with each pixel
  typedef struct packed {
    logic emit;   // a result leaves for this pixel
    logic inner;  // centre lies inside the border
    logic done;   // last result of the frame
  } pos_ctl_t;

endpackage

>>> rtl/bm3_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_line_buf: two-row line store
// One entry per column holding the flags of the two previous rows;
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bm3_line_buf #(
  parameter int DEPTH = 512
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_i,
  output logic [bm3_pkg::LB_W-1:0]            rd_data_o,
  input  logic                                wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr_i,
  input  logic [bm3_pkg::LB_W-1:0]            wr_data_i
);

  logic [bm3_pkg::LB_W-1:0] mem [DEPTH];
  logic [bm3_pkg::LB_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/bm3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_window: 3x3 flag window and decision
// Shifts in one column per pixel, decides erosion or dilation on the window.
// ----------------------------------------------------------------------------
module bm3_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [bm3_pkg::COL_W-1:0]   col_i,    // {south, centre, north}
  input  logic                        mode_i,
  output logic                        on_o
);

  logic [bm3_pkg::WIN_W-1:0] win_q, win_d;

  // columns: west in the low bits, east in the high bits
  assign win_d = {col_i, win_q[bm3_pkg::WIN_W-1:bm3_pkg::COL_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  logic [8:0] full_v;
  logic [7:0] nbr;
  logic       centre_nz;
  logic       hit;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      full_v[k] = win_q[k*bm3_pkg::FLAG_W + bm3_pkg::FLAG_FULL];
    end
  end

  // nz bit of (col,row) sits at col*6 + row*2
  assign centre_nz = win_q[8];
  assign nbr = {win_q[16],   // se
                win_q[10],   // s
                win_q[4],    // sw
                win_q[2],    // w
                win_q[0],    // nw
                win_q[6],    // n
                win_q[12],   // ne
                win_q[14]};  // e

  assign hit = centre_nz && ((nbr == bm3_pkg::HIT_ISOLATED) ||
                             (nbr == bm3_pkg::HIT_E_NE_N) ||
                             (nbr == bm3_pkg::HIT_SE_ONLY));

  always_comb begin
    if (mode_i == bm3_pkg::MODE_DILATE) begin
      on_o = |full_v;
    end else begin
      on_o = (&full_v) | hit;
    end
  end

endmodule

>>> rtl/binary_morphology_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3: 3x3 binary erosion / dilation on a pixel stream
// Top level: counters, pipeline control, line store, window and output.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries 8-bit pixels in raster order (tdata[7:0] = pixel). One
//   request is taken per cycle when tready is high.
//   m_axis returns one result per pixel position once that position's lower
//   right neighbour has arrived: tdata[0] = result_on (1 = pixel 255),
//   tlast = frame_done. The first W+1 pixels of a frame give no result; the
//   final W+1 positions of a frame (border) are never sent.
//   Path: once the pixel that completes its neighbourhood is taken, its result
//   passes the line store read (at the take), then the window, then the
//   output register.
//   Throughput: one pixel per cycle while not stalled, set by the single line
//   store port pair (one read and one write per cycle).
//   Stall: the output register holds while it has a result and m_axis_tready
//   is low; the pipeline keeps moving while its last stage carries no result,
//   and halts (tready low) only when a pending result has nowhere to go.
//   Reset: mode erosion, 512 x 512, counters and window cleared. The line
//   store is not cleared and needs no sweep; the first two rows rebuild it.
//   Configuration: cfg_we_i with cfg_idx_i (0 mode, 1 width, 2 height); a
//   geometry write restarts the frame. Write only while the block is idle.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // pixel input
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] pixel
  // result output
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [0] result_on, [7:1] zero
  output logic                       m_axis_tlast,   // frame_done
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [bm3_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int CW   = $clog2(MAX_WIDTH);       // column counter / address
  localparam int WW   = $clog2(MAX_WIDTH + 1);   // holds MAX_WIDTH itself
  localparam int CMPW = (WW > bm3_pkg::CFG_W) ? WW : bm3_pkg::CFG_W;
  localparam int RW   = bm3_pkg::CFG_W;          // row counter

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                      mode_q;
  logic [bm3_pkg::CFG_W-1:0] width_q;
  logic [bm3_pkg::CFG_W-1:0] height_q;
  logic                      geom_wr;

  assign geom_wr = cfg_we_i && ((cfg_idx_i == bm3_pkg::CFG_WIDTH) ||
                                (cfg_idx_i == bm3_pkg::CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bm3_pkg::MODE_ERODE;
      width_q  <= bm3_pkg::CFG_W'(512);
      height_q <= bm3_pkg::CFG_W'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bm3_pkg::CFG_MODE:   mode_q   <= cfg_data_i[0];
        bm3_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        bm3_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // effective geometry: width clamped to [3, MAX_WIDTH], height at least 3
  logic [CMPW-1:0]           width_ext;
  logic [WW-1:0]             w_eff;
  logic [CW-1:0]             col_last;
  logic [RW-1:0]             h_eff;
  logic [RW-1:0]             row_last;

  assign width_ext = CMPW'(width_q);

  always_comb begin
    if (width_ext < CMPW'(3)) begin
      w_eff = WW'(3);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_ext);
    end
  end

  assign col_last = CW'(w_eff - WW'(1));
  assign h_eff    = (height_q < RW'(3)) ? RW'(3) : height_q;
  assign row_last = h_eff - RW'(1);

  // --------------------------------------------------------------------------
  // pipeline control: everything advances together unless a result in the
  // last stage finds the output register full and not being taken
  // --------------------------------------------------------------------------
  logic              adv;
  logic              in_take;
  logic              out_vld_q;
  logic              out_on_q;
  logic              out_done_q;

  logic              s1_vld_q;
  logic [bm3_pkg::FLAG_W-1:0] s1_flag_q;
  logic [CW-1:0]     s1_col_q;
  bm3_pkg::pos_ctl_t s1_ctl_q;

  logic              s2_vld_q;
  bm3_pkg::pos_ctl_t s2_ctl_q;

  assign adv     = !(out_vld_q && !m_axis_tready && s2_vld_q && s2_ctl_q.emit);
  assign in_take = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  // --------------------------------------------------------------------------
  // raster position counters
  // --------------------------------------------------------------------------
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  bm3_pkg::pos_ctl_t pos_ctl;
  logic [bm3_pkg::FLAG_W-1:0] pix_flag;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_take) begin
      if (col_q == col_last) begin
        col_d = '0;
        row_d = (row_q == row_last) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (geom_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_ctl.emit  = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
  assign pos_ctl.inner = (row_q >= RW'(2)) && (col_q >= CW'(2));
  assign pos_ctl.done  = (row_q == row_last) && (col_q == col_last);

  assign pix_flag[bm3_pkg::FLAG_FULL] = (s_axis_tdata == bm3_pkg::FULL_VAL);
  assign pix_flag[bm3_pkg::FLAG_NZ]   = (s_axis_tdata != 8'd0);

  // --------------------------------------------------------------------------
  // stage 1: line store read in flight
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_flag_q <= pix_flag;
      s1_col_q  <= col_q;
      s1_ctl_q  <= pos_ctl;
    end
  end

  logic [bm3_pkg::LB_W-1:0]  lb_rdata;
  logic                      lb_we;
  logic [bm3_pkg::LB_W-1:0]  lb_wdata;
  logic [bm3_pkg::COL_W-1:0] new_col;

  assign lb_we    = adv && s1_vld_q;
  // top row takes the old middle row, middle row takes the new pixel
  assign lb_wdata = {s1_flag_q, lb_rdata[bm3_pkg::LB_W-1:bm3_pkg::FLAG_W]};
  assign new_col  = {s1_flag_q, lb_rdata};

  bm3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rdata),
    .wr_en_i   (lb_we),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wdata)
  );

  // --------------------------------------------------------------------------
  // stage 2: window holds this pixel's neighbourhood
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  logic win_on;

  bm3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (lb_we),
    .col_i   (new_col),
    .mode_i  (mode_q),
    .on_o    (win_on)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic out_load;

  assign out_load = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= s2_vld_q && s2_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_on_q   <= s2_ctl_q.inner && win_on;
      out_done_q <= s2_ctl_q.done;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_on_q};
  assign m_axis_tlast  = out_done_q;

`ifndef SYNTHESIS
  // a taken pixel always lands in stage 1
  a_take_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_vld_q)
    else $error("accepted pixel lost before stage 1");

  // line store read and write never hit the same column in one cycle
  a_lb_no_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lb_we && in_take) |-> (s1_col_q != col_q))
    else $error("line store read/write address clash");

  // column counter stays inside the active width
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= col_last)
    else $error("column counter beyond row end");

  // a stalled result stays put until it is taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");
`endif

endmodule
